>>> rtl/abwf_pkg.sv
`default_nettype none

package abwf_pkg;

  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned BIT_W     = 5;
  localparam int unsigned IDX_W     = 10;
  localparam int unsigned CNT_W     = 11;
  localparam int unsigned FUNC_W    = 2;

  localparam logic [CNT_W-1:0]  BIT_COUNT_RST = 11'd1024;

  localparam logic [FUNC_W-1:0] FUNC_SET   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE,
    ST_SCAN
  } state_e;

  typedef struct packed {
    logic             any_set;
    logic [BIT_W-1:0] set_pos;
    logic             any_clear;
    logic [BIT_W-1:0] clear_pos;
  } hit_t;

endpackage

`default_nettype wire

>>> rtl/abwf_word_scan.sv
`default_nettype none

module abwf_word_scan (
  input  logic [abwf_pkg::WORD_BITS-1:0] word_i,
  input  logic [abwf_pkg::WORD_BITS-1:0] mask_i,
  output abwf_pkg::hit_t                 hit_o
);

  logic [abwf_pkg::WORD_BITS-1:0] set_bits;
  logic [abwf_pkg::WORD_BITS-1:0] clr_bits;

  always_comb begin
    set_bits = word_i & mask_i;
    clr_bits = ~word_i & mask_i;
    hit_o.any_set   = |set_bits;
    hit_o.any_clear = |clr_bits;
    hit_o.set_pos   = '0;
    hit_o.clear_pos = '0;
    // lowest index wins
    for (int i = abwf_pkg::WORD_BITS - 1; i >= 0; i--) begin
      if (set_bits[i]) begin
        hit_o.set_pos = abwf_pkg::BIT_W'(i);
      end
      if (clr_bits[i]) begin
        hit_o.clear_pos = abwf_pkg::BIT_W'(i);
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/allocation_bitmap_with_find_first_unit.sv
// channel   signals                                   direction  handshake
// request   start_i, func_i, bit_index_i              in         start_i && !busy_o
// result    valid_o, in_range_o, old_bit_o, any_set_o  out        valid_o, one cycle
//           first_set_o, any_clear_o, first_clear_o
// config    cfg_valid_i, cfg_ready_o, cfg_data_i       in         cfg_valid_i && cfg_ready_o
//
// after reset the word memory is zeroed, one word a cycle, with busy_o high
// a request is accepted in idle, gets a read-modify-write when in range,
// then a word scan over the words in use (n = bits in use, early stop when both found)
// the result strobe comes in the idle cycle after, which can accept the next request,
// so requests are handled one at a time, paced by the one-word memory port
// the result is shown for one cycle and cannot be held off; busy_o drops with it
`default_nettype none

module allocation_bitmap_with_find_first_unit #(
  parameter int unsigned MAX_BITS = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [abwf_pkg::FUNC_W-1:0]         func_i,
  input  logic [abwf_pkg::IDX_W-1:0]          bit_index_i,
  output logic                                valid_o,
  output logic                                in_range_o,
  output logic                                old_bit_o,
  output logic                                any_set_o,
  output logic [abwf_pkg::IDX_W-1:0]          first_set_o,
  output logic                                any_clear_o,
  output logic [abwf_pkg::IDX_W-1:0]          first_clear_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [abwf_pkg::CNT_W-1:0]          cfg_data_i
);

  localparam int unsigned WORD_DEPTH =
      (MAX_BITS + abwf_pkg::WORD_BITS - 1) / abwf_pkg::WORD_BITS;
  localparam int unsigned AW   = (WORD_DEPTH > 1) ? $clog2(WORD_DEPTH) : 1;
  localparam int unsigned CW   = $clog2(WORD_DEPTH + 1);
  localparam int unsigned MB_W = $clog2(MAX_BITS + 1);
  localparam int unsigned NW_W = (abwf_pkg::CNT_W > MB_W) ? abwf_pkg::CNT_W : MB_W;
  localparam logic [NW_W-1:0] MAX_N     = NW_W'(MAX_BITS);
  localparam logic [CW-1:0]   LAST_WORD = CW'(WORD_DEPTH - 1);

  localparam int unsigned WB = abwf_pkg::WORD_BITS;
  localparam int unsigned BW = abwf_pkg::BIT_W;
  localparam int unsigned IW = abwf_pkg::IDX_W;

  logic [WB-1:0] mem [WORD_DEPTH];
  logic [WB-1:0] rd_data_q;
  logic          mem_we;
  logic          mem_re;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  logic [WB-1:0] mem_wdata;

  abwf_pkg::state_e state_q, state_d;
  logic [abwf_pkg::CNT_W-1:0]  bit_count_q;
  logic [abwf_pkg::FUNC_W-1:0] func_q, func_d;
  logic [IW-1:0]  idx_q, idx_d;
  logic           inr_q, inr_d;
  logic           old_q, old_d;
  logic [CW-1:0]  full_q, full_d;
  logic [BW-1:0]  rem_q, rem_d;
  logic [CW-1:0]  nwords_q, nwords_d;
  logic [CW-1:0]  issue_q, issue_d;
  logic [CW-1:0]  proc_q, proc_d;
  logic           pend_q, pend_d;
  logic           fs_q, fs_d;
  logic           fc_q, fc_d;
  logic [IW-1:0]  fset_q, fset_d;
  logic [IW-1:0]  fclr_q, fclr_d;
  logic           valid_q, valid_d;

  logic [NW_W-1:0] cnt_ext;
  logic [NW_W-1:0] used;
  logic            in_rng;
  logic [CW-1:0]   full_words;
  logic [BW-1:0]   rem_bits;
  logic [WB-1:0]   ones;
  logic [WB-1:0]   scan_mask;
  logic [BW-1:0]   upd_pos;
  abwf_pkg::hit_t  hit;

  // bits in use and request decode
  always_comb begin
    cnt_ext    = NW_W'(bit_count_q);
    used       = (cnt_ext > MAX_N) ? MAX_N : cnt_ext;
    in_rng     = NW_W'(bit_index_i) < used;
    full_words = CW'(used >> BW);
    rem_bits   = used[BW-1:0];
    ones       = '1;
    upd_pos    = idx_q[BW-1:0];
  end

  // in-use part of the word under scan
  always_comb begin
    if (proc_q < full_q) begin
      scan_mask = '1;
    end else if (proc_q == full_q) begin
      scan_mask = ~(ones << rem_q);
    end else begin
      scan_mask = '0;
    end
  end

  abwf_word_scan u_word_scan (
    .word_i (rd_data_q),
    .mask_i (scan_mask),
    .hit_o  (hit)
  );

  always_comb begin
    state_d   = state_q;
    func_d    = func_q;
    idx_d     = idx_q;
    inr_d     = inr_q;
    old_d     = old_q;
    full_d    = full_q;
    rem_d     = rem_q;
    nwords_d  = nwords_q;
    issue_d   = issue_q;
    proc_d    = proc_q;
    pend_d    = pend_q;
    fs_d      = fs_q;
    fc_d      = fc_q;
    fset_d    = fset_q;
    fclr_d    = fclr_q;
    valid_d   = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = issue_q[AW-1:0];
    mem_raddr = issue_q[AW-1:0];
    mem_wdata = '0;

    unique case (state_q)
      abwf_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
        if (issue_q == LAST_WORD) begin
          issue_d = '0;
          state_d = abwf_pkg::ST_IDLE;
        end else begin
          issue_d = issue_q + CW'(1);
        end
      end

      abwf_pkg::ST_IDLE: begin
        if (start_i) begin
          func_d   = func_i;
          idx_d    = bit_index_i;
          inr_d    = in_rng;
          old_d    = 1'b0;
          full_d   = full_words;
          rem_d    = rem_bits;
          nwords_d = full_words + CW'(|rem_bits);
          issue_d  = '0;
          pend_d   = 1'b0;
          fs_d     = 1'b0;
          fc_d     = 1'b0;
          fset_d   = '0;
          fclr_d   = '0;
          if (in_rng) begin
            mem_re    = 1'b1;
            mem_raddr = AW'(bit_index_i >> BW);
            state_d   = abwf_pkg::ST_UPDATE;
          end else begin
            state_d = abwf_pkg::ST_SCAN;
          end
        end
      end

      abwf_pkg::ST_UPDATE: begin
        old_d     = rd_data_q[upd_pos];
        mem_we    = 1'b1;
        mem_waddr = AW'(idx_q >> BW);
        mem_wdata = rd_data_q;
        if (func_q == abwf_pkg::FUNC_SET) begin
          mem_wdata[upd_pos] = 1'b1;
        end else if (func_q == abwf_pkg::FUNC_CLEAR) begin
          mem_wdata[upd_pos] = 1'b0;
        end
        state_d = abwf_pkg::ST_SCAN;
      end

      abwf_pkg::ST_SCAN: begin
        if (pend_q) begin
          if (!fs_q && hit.any_set) begin
            fs_d   = 1'b1;
            fset_d = IW'({proc_q, hit.set_pos});
          end
          if (!fc_q && hit.any_clear) begin
            fc_d   = 1'b1;
            fclr_d = IW'({proc_q, hit.clear_pos});
          end
        end
        if ((issue_q < nwords_q) && !(fs_d && fc_d)) begin
          mem_re    = 1'b1;
          mem_raddr = issue_q[AW-1:0];
          proc_d    = issue_q;
          issue_d   = issue_q + CW'(1);
          pend_d    = 1'b1;
        end else begin
          pend_d  = 1'b0;
          valid_d = 1'b1;
          state_d = abwf_pkg::ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= abwf_pkg::ST_CLEAR;
      bit_count_q <= abwf_pkg::BIT_COUNT_RST;
      issue_q     <= '0;
      pend_q      <= 1'b0;
      valid_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      issue_q <= issue_d;
      pend_q  <= pend_d;
      valid_q <= valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        bit_count_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    func_q   <= func_d;
    idx_q    <= idx_d;
    inr_q    <= inr_d;
    old_q    <= old_d;
    full_q   <= full_d;
    rem_q    <= rem_d;
    nwords_q <= nwords_d;
    proc_q   <= proc_d;
    fs_q     <= fs_d;
    fc_q     <= fc_d;
    fset_q   <= fset_d;
    fclr_q   <= fclr_d;
  end

  assign busy_o        = (state_q != abwf_pkg::ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign valid_o       = valid_q;
  assign in_range_o    = inr_q;
  assign old_bit_o     = old_q;
  assign any_set_o     = fs_q;
  assign first_set_o   = fset_q;
  assign any_clear_o   = fc_q;
  assign first_clear_o = fclr_q;

endmodule

`default_nettype wire

>>> verif/tb.sv
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned BITMAP_BITS = 1024;
  localparam logic [abwf_pkg::FUNC_W-1:0] FUNC_TEST  = 2'd0;
  localparam logic [abwf_pkg::FUNC_W-1:0] FUNC_SPARE = 2'd3;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned MAX_GAP = 40;
  localparam int unsigned PHASE_ITEMS = 128;

  typedef struct packed {
    logic                       in_range;
    logic                       old_bit;
    logic                       any_set;
    logic [abwf_pkg::IDX_W-1:0] first_set;
    logic                       any_clear;
    logic [abwf_pkg::IDX_W-1:0] first_clear;
  } bitmap_result_t;

  class bitmap_scoreboard;
    logic [BITMAP_BITS-1:0]     bits;
    logic [abwf_pkg::CNT_W-1:0] count;
    bitmap_result_t             expected_q[$];
    int                         errors;

    function new();
      bits   = '0;
      count  = abwf_pkg::BIT_COUNT_RST;
      errors = 0;
    endfunction

    function void set_count(logic [abwf_pkg::CNT_W-1:0] value);
      count = value;
    endfunction

    function int unsigned used_bits();
      return (count > BITMAP_BITS) ? BITMAP_BITS : count;
    endfunction

    function void find_first(output logic any_s, output logic [abwf_pkg::IDX_W-1:0] fs,
                             output logic any_c, output logic [abwf_pkg::IDX_W-1:0] fc);
      int unsigned n;
      n = used_bits();
      any_s = 1'b0;
      fs    = '0;
      any_c = 1'b0;
      fc    = '0;
      for (int unsigned i = 0; i < n && !(any_s && any_c); i++) begin
        if (bits[i] && !any_s) begin
          any_s = 1'b1;
          fs    = abwf_pkg::IDX_W'(i);
        end
        if (!bits[i] && !any_c) begin
          any_c = 1'b1;
          fc    = abwf_pkg::IDX_W'(i);
        end
      end
    endfunction

    function void note_request(logic [abwf_pkg::FUNC_W-1:0] func,
                               logic [abwf_pkg::IDX_W-1:0] idx);
      bitmap_result_t r;
      r.in_range = (idx < used_bits());
      r.old_bit  = r.in_range ? bits[idx] : 1'b0;
      if (r.in_range) begin
        if (func == abwf_pkg::FUNC_SET) begin
          bits[idx] = 1'b1;
        end else if (func == abwf_pkg::FUNC_CLEAR) begin
          bits[idx] = 1'b0;
        end
      end
      find_first(r.any_set, r.first_set, r.any_clear, r.first_clear);
      expected_q.push_back(r);
    endfunction

    function void compare_field(string name, int unsigned exp_v, int unsigned got_v);
      if (exp_v != got_v) begin
        $error("%s expected %0d got %0d", name, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_result(bitmap_result_t got);
      bitmap_result_t exp_r;
      if (expected_q.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      compare_field("in_range", exp_r.in_range, got.in_range);
      compare_field("old_bit", exp_r.old_bit, got.old_bit);
      compare_field("any_set", exp_r.any_set, got.any_set);
      compare_field("first_set", exp_r.first_set, got.first_set);
      compare_field("any_clear", exp_r.any_clear, got.any_clear);
      compare_field("first_clear", exp_r.first_clear, got.first_clear);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        start_i = 1'b0;
  logic                        busy_o;
  logic [abwf_pkg::FUNC_W-1:0] func_i = '0;
  logic [abwf_pkg::IDX_W-1:0]  bit_index_i = '0;
  logic                        valid_o;
  logic                        in_range_o;
  logic                        old_bit_o;
  logic                        any_set_o;
  logic [abwf_pkg::IDX_W-1:0]  first_set_o;
  logic                        any_clear_o;
  logic [abwf_pkg::IDX_W-1:0]  first_clear_o;
  logic                        cfg_valid_i = 1'b0;
  logic                        cfg_ready_o;
  logic [abwf_pkg::CNT_W-1:0]  cfg_data_i = '0;

  bitmap_scoreboard sb = new();
  bitmap_result_t   seen;
  int unsigned      quiet_cycles = 0;

  allocation_bitmap_with_find_first_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .func_i       (func_i),
    .bit_index_i  (bit_index_i),
    .valid_o      (valid_o),
    .in_range_o   (in_range_o),
    .old_bit_o    (old_bit_o),
    .any_set_o    (any_set_o),
    .first_set_o  (first_set_o),
    .any_clear_o  (any_clear_o),
    .first_clear_o(first_clear_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      seen = {in_range_o, old_bit_o, any_set_o, first_set_o, any_clear_o, first_clear_o};
      sb.check_result(seen);
    end
  end

  // stall watchdog
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || valid_o || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_request(input logic [abwf_pkg::FUNC_W-1:0] func,
                              input logic [abwf_pkg::IDX_W-1:0] idx,
                              input int unsigned idle_pct);
    start_i     <= 1'b1;
    func_i      <= func;
    bit_index_i <= idx;
    do @(posedge clk_i); while (busy_o);
    sb.note_request(func, idx);
    if ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, MAX_GAP)) @(posedge clk_i);
    end
  endtask

  task automatic wait_idle();
    start_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_count(input logic [abwf_pkg::CNT_W-1:0] value);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_count(value);
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= abwf_pkg::CNT_W'($urandom);
  endtask

  task automatic send_random(input int unsigned idle_pct);
    int unsigned                 roll;
    int unsigned                 n;
    int unsigned                 span;
    logic [abwf_pkg::FUNC_W-1:0] func;
    logic [abwf_pkg::IDX_W-1:0]  idx;
    logic                        any_s;
    logic                        any_c;
    logic [abwf_pkg::IDX_W-1:0]  fs;
    logic [abwf_pkg::IDX_W-1:0]  fc;
    n    = sb.used_bits();
    roll = $urandom_range(99);
    span = (n + 3 > 64) ? 63 : n + 2;
    func = ($urandom_range(99) < 55) ? abwf_pkg::FUNC_SET : abwf_pkg::FUNC_CLEAR;
    idx  = abwf_pkg::IDX_W'($urandom_range(span));
    if (roll < 25) begin
      // allocator pattern: grab lowest free or release lowest used
      sb.find_first(any_s, fs, any_c, fc);
      if (($urandom_range(99) < 65 && any_c) || !any_s) begin
        func = abwf_pkg::FUNC_SET;
        idx  = fc;
      end else begin
        func = abwf_pkg::FUNC_CLEAR;
        idx  = fs;
      end
    end else if (roll < 40) begin
      idx = abwf_pkg::IDX_W'($urandom);
      if ($urandom_range(3) == 0) begin
        func = abwf_pkg::FUNC_W'($urandom);
      end
    end else if (roll < 52) begin
      idx = abwf_pkg::IDX_W'((n < 2 ? 0 : n - 2) + $urandom_range(3));
    end else if (roll < 64) begin
      func = ($urandom_range(3) == 0) ? FUNC_SPARE : FUNC_TEST;
    end
    send_request(func, idx, idle_pct);
  endtask

  initial begin
    int unsigned phase_count[12];
    int unsigned phase_idle[4];
    phase_count = '{1024, 40, 1, 96, 1024, 0, 2047, 700, 33, 32, 1025, 64};
    phase_idle  = '{0, 64, 0, 13};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty map, extremes, repeated set and clear, spare op code
    send_request(FUNC_TEST, 10'd0, 0);
    send_request(abwf_pkg::FUNC_SET, 10'd0, 0);
    send_request(abwf_pkg::FUNC_SET, 10'd1023, 0);
    send_request(FUNC_TEST, 10'd1023, 0);
    send_request(FUNC_SPARE, 10'd1023, 0);
    send_request(abwf_pkg::FUNC_CLEAR, 10'd0, 0);
    send_request(abwf_pkg::FUNC_SET, 10'd5, 0);
    send_request(abwf_pkg::FUNC_SET, 10'd5, 0);
    send_request(abwf_pkg::FUNC_CLEAR, 10'd5, 0);
    send_request(abwf_pkg::FUNC_CLEAR, 10'd5, 0);
    send_request(FUNC_TEST, 10'd512, 0);
    // no bits in use
    write_count(11'd0);
    send_request(FUNC_TEST, 10'd0, 0);
    send_request(abwf_pkg::FUNC_SET, 10'd7, 0);
    // oversized count acts as full map
    write_count(11'd2047);
    send_request(FUNC_TEST, 10'd1023, 0);
    send_request(abwf_pkg::FUNC_CLEAR, 10'd1023, 0);
    send_request(abwf_pkg::FUNC_SET, 10'd1023, 0);
    // single bit, full map
    write_count(11'd1);
    send_request(abwf_pkg::FUNC_SET, 10'd0, 0);
    send_request(FUNC_TEST, 10'd1, 0);
    send_request(abwf_pkg::FUNC_SET, 10'd1023, 0);
    send_request(abwf_pkg::FUNC_CLEAR, 10'd0, 0);

    for (int p = 0; p < 12; p++) begin
      write_count(abwf_pkg::CNT_W'(phase_count[p]));
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        send_random(phase_idle[p % 4]);
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.pending() != 0) begin
      $error("%0d results never arrived", sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
